### hdl/plic_pkg.sv
// ----------------------------------------------------------------------------
// plic_pkg: shared types, constants and functions
// Register map constants, command codes and source selection helpers.
// ----------------------------------------------------------------------------
package plic_pkg;

  localparam int NUM_SOURCES  = 32;
  localparam int NUM_CONTEXTS = 2;
  localparam int PRIO_MAX     = 7;

  localparam int SRC_W  = $clog2(NUM_SOURCES);
  localparam int CTX_W  = 1;
  localparam int PRIO_W = $clog2(PRIO_MAX + 1);
  localparam int ADDR_W = 22;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-1:0] PEND_BASE = ADDR_W'(32'h0000_1000);
  localparam logic [ADDR_W-1:0] EN_BASE   = ADDR_W'(32'h0000_2000);
  localparam logic [ADDR_W-1:0] CTX_BASE  = ADDR_W'(32'h0020_0000);

  localparam logic [11:0] CTX_REG_THRESHOLD = 12'h000;
  localparam logic [11:0] CTX_REG_CLAIM     = 12'h004;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_SAMPLE = 2'd2
  } cmd_t;

  typedef logic [NUM_SOURCES-1:0][PRIO_W-1:0] prio_arr_t;
  typedef logic [NUM_SOURCES-1:0]             src_vec_t;

  function automatic logic [PRIO_W-1:0] sat_prio(logic [DATA_W-1:0] v);
    logic [PRIO_W-1:0] r;
    if (v > DATA_W'(PRIO_MAX)) begin
      r = PRIO_W'(PRIO_MAX);
    end else begin
      r = v[PRIO_W-1:0];
    end
    return r;
  endfunction

  function automatic src_vec_t above_mask(prio_arr_t prio, logic [PRIO_W-1:0] thr);
    src_vec_t m;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      m[s] = (prio[s] > thr);
    end
    return m;
  endfunction

  // highest priority wins, lowest ID on ties
  function automatic logic [SRC_W-1:0] best_src(src_vec_t elig, prio_arr_t prio);
    logic [PRIO_MAX:0] lvl_any;
    logic [PRIO_W-1:0] top;
    src_vec_t          hit;
    src_vec_t          low;
    logic [SRC_W-1:0]  id;
    for (int lv = 0; lv <= PRIO_MAX; lv++) begin
      lvl_any[lv] = 1'b0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        lvl_any[lv] = lvl_any[lv] | (elig[s] & (prio[s] == PRIO_W'(lv)));
      end
    end
    top = '0;
    for (int lv = 0; lv <= PRIO_MAX; lv++) begin
      if (lvl_any[lv]) begin
        top = PRIO_W'(lv);
      end
    end
    for (int s = 0; s < NUM_SOURCES; s++) begin
      hit[s] = elig[s] & (prio[s] == top);
    end
    low = hit & (~hit + src_vec_t'(1));
    id  = '0;
    for (int s = 0; s < NUM_SOURCES; s++) begin
      id = id | (low[s] ? SRC_W'(s) : '0);
    end
    return id;
  endfunction

endpackage

### hdl/platform_interrupt_controller.sv
// ----------------------------------------------------------------------------
// platform_interrupt_controller: platform-level interrupt controller
// Priorities, pending and in-flight bits, per-context enables, thresholds,
// claim and complete, behind a bus read/write and line sample channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per command: a bus
//   read, a bus write, or a sample of the source lines. Each beat yields one
//   result beat on the output channel (out_valid/out_ready) with read data
//   (claim ID on a claim read), the per-context notification after the
//   update, and a flag for an address that decodes to no register.
//   An accepted beat lands in an input register; once the result register
//   is empty or being taken, the update pass changes the state and loads it,
//   raising out_valid. Throughput: one beat per cycle while the receiver
//   takes results, set by the single update pass from input to result reg.
//   A stalled receiver holds the result register; one more beat waits in the
//   input register, after which in_ready drops until the result is taken.
//   Reset clears all priorities, pending, in-flight, enable and threshold
//   state and empties both registers.
// ----------------------------------------------------------------------------
module platform_interrupt_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_cmd,
  input  logic [plic_pkg::ADDR_W-1:0]          in_addr,
  input  logic [plic_pkg::DATA_W-1:0]          in_wdata,
  input  logic [plic_pkg::NUM_SOURCES-1:0]     in_irq_lines,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [plic_pkg::DATA_W-1:0]          out_rdata,
  output logic [plic_pkg::NUM_CONTEXTS-1:0]    out_irq_out,
  output logic                                 out_bad_access
);

  localparam int NS = plic_pkg::NUM_SOURCES;
  localparam int NC = plic_pkg::NUM_CONTEXTS;
  localparam int PW = plic_pkg::PRIO_W;
  localparam int SW = plic_pkg::SRC_W;
  localparam int AW = plic_pkg::ADDR_W;
  localparam int DW = plic_pkg::DATA_W;

  logic                  s1_valid_r;
  logic [1:0]            in_cmd_r;
  logic [AW-1:0]         in_addr_r;
  logic [DW-1:0]         in_wdata_r;
  logic [NS-1:0]         in_lines_r;

  plic_pkg::prio_arr_t   prio_r, prio_nxt;
  plic_pkg::src_vec_t    pend_r, pend_nxt;
  plic_pkg::src_vec_t    infl_r, infl_nxt;
  plic_pkg::src_vec_t    en_r   [NC];
  plic_pkg::src_vec_t    en_nxt [NC];
  logic [PW-1:0]         thr_r  [NC];
  logic [PW-1:0]         thr_nxt[NC];

  logic                  out_valid_r;
  logic [DW-1:0]         out_rdata_r, rdata_nxt;
  logic [NC-1:0]         out_irq_r, irq_nxt;
  logic                  out_bad_r, bad_nxt;

  logic                  s1_fire;
  logic                  wr;
  logic [SW-1:0]         src;
  logic [plic_pkg::CTX_W-1:0] cx_en, cx_ctx;
  logic [11:0]           ctx_reg;
  logic [SW-1:0]         claim_id;
  plic_pkg::src_vec_t    elig_cx;
  logic [SW-1:0]         cpl_id;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  assign wr      = (plic_pkg::cmd_t'(in_cmd_r) == plic_pkg::CMD_WRITE);
  assign src     = in_addr_r[SW+1:2];
  assign cx_en   = in_addr_r[7];
  assign cx_ctx  = in_addr_r[12];
  assign ctx_reg = in_addr_r[11:0];
  assign cpl_id  = in_wdata_r[SW-1:0];

  assign elig_cx  = pend_r & en_r[cx_ctx] & plic_pkg::above_mask(prio_r, thr_r[cx_ctx]);
  assign claim_id = plic_pkg::best_src(elig_cx, prio_r);

  always_comb begin
    prio_nxt  = prio_r;
    pend_nxt  = pend_r;
    infl_nxt  = infl_r;
    en_nxt    = en_r;
    thr_nxt   = thr_r;
    rdata_nxt = '0;
    bad_nxt   = 1'b0;
    case (plic_pkg::cmd_t'(in_cmd_r)) inside
      plic_pkg::CMD_SAMPLE: begin
        pend_nxt = pend_r | (in_lines_r & ~infl_r & ~plic_pkg::src_vec_t'(1));
      end
      plic_pkg::CMD_READ, plic_pkg::CMD_WRITE: begin
        if (in_addr_r[1:0] != 2'b00) begin
          bad_nxt = 1'b1;
        end else if (in_addr_r < plic_pkg::PEND_BASE) begin
          if (in_addr_r[11:SW+2] != '0) begin
            bad_nxt = 1'b1;
          end else if (wr) begin
            if (src != '0) begin
              prio_nxt[src] = plic_pkg::sat_prio(in_wdata_r);
            end
          end else begin
            rdata_nxt = DW'(prio_r[src]);
          end
        end else if (in_addr_r < plic_pkg::EN_BASE) begin
          if (in_addr_r != plic_pkg::PEND_BASE) begin
            bad_nxt = 1'b1;
          end else if (!wr) begin
            rdata_nxt = DW'(pend_r);
          end
        end else if (in_addr_r < plic_pkg::CTX_BASE) begin
          if (in_addr_r[20:8] != plic_pkg::EN_BASE[20:8] || in_addr_r[6:2] != '0) begin
            bad_nxt = 1'b1;
          end else if (wr) begin
            en_nxt[cx_en] = in_wdata_r[NS-1:0] & ~plic_pkg::src_vec_t'(1);
          end else begin
            rdata_nxt = DW'(en_r[cx_en]);
          end
        end else begin
          if (in_addr_r[20:13] != '0 ||
              (ctx_reg != plic_pkg::CTX_REG_THRESHOLD && ctx_reg != plic_pkg::CTX_REG_CLAIM)) begin
            bad_nxt = 1'b1;
          end else if (ctx_reg == plic_pkg::CTX_REG_THRESHOLD) begin
            if (wr) begin
              thr_nxt[cx_ctx] = plic_pkg::sat_prio(in_wdata_r);
            end else begin
              rdata_nxt = DW'(thr_r[cx_ctx]);
            end
          end else if (wr) begin
            if (in_wdata_r[DW-1:SW] == '0 && cpl_id != '0 && en_r[cx_ctx][cpl_id]) begin
              infl_nxt[cpl_id] = 1'b0;
            end
          end else begin
            if (claim_id != '0) begin
              pend_nxt[claim_id] = 1'b0;
              infl_nxt[claim_id] = 1'b1;
            end
            rdata_nxt = DW'(claim_id);
          end
        end
      end
      default: begin
      end
    endcase
    for (int c = 0; c < NC; c++) begin
      irq_nxt[c] = |(pend_nxt & en_nxt[c] & plic_pkg::above_mask(prio_nxt, thr_nxt[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prio_r      <= '0;
      pend_r      <= '0;
      infl_r      <= '0;
      for (int c = 0; c < NC; c++) begin
        en_r[c]  <= '0;
        thr_r[c] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        prio_r      <= prio_nxt;
        pend_r      <= pend_nxt;
        infl_r      <= infl_nxt;
        en_r        <= en_nxt;
        thr_r       <= thr_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_cmd_r   <= in_cmd;
      in_addr_r  <= in_addr;
      in_wdata_r <= in_wdata;
      in_lines_r <= in_irq_lines;
    end
    if (s1_fire) begin
      out_rdata_r <= rdata_nxt;
      out_irq_r   <= irq_nxt;
      out_bad_r   <= bad_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_rdata      = out_rdata_r;
  assign out_irq_out    = out_irq_r;
  assign out_bad_access = out_bad_r;

endmodule

### tb/sv/tb_platform_interrupt_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_platform_interrupt_controller: self-checking bench for the PLIC
// Drives bus reads, bus writes and line samples through the input channel
// with random gaps, tracks priorities, pending, in-flight, enable and
// threshold state alongside the block, and compares every result beat
// (read data or claim ID, per-context notification, decode error) in order.
// ----------------------------------------------------------------------------
module tb_platform_interrupt_controller;
  import plic_pkg::*;

  localparam logic [1:0]        CMD_NOP        = 2'd3;
  localparam logic [ADDR_W-1:0] EN_STRIDE      = ADDR_W'(32'h80);
  localparam logic [ADDR_W-1:0] CTX_STRIDE     = ADDR_W'(32'h1000);
  localparam int                EN_WORDS       = (NUM_SOURCES + 31) / 32;
  localparam int                RANDOM_BEATS   = 1120;
  localparam int                WATCHDOG_LIMIT = 2000;
  localparam int                MAX_REPORTS    = 10;

  typedef struct packed {
    logic [DATA_W-1:0]       rdata;
    logic [NUM_CONTEXTS-1:0] irq;
    logic                    bad;
  } plic_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [1:0]              in_cmd = '0;
  logic [ADDR_W-1:0]       in_addr = '0;
  logic [DATA_W-1:0]       in_wdata = '0;
  logic [NUM_SOURCES-1:0]  in_irq_lines = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [DATA_W-1:0]       out_rdata;
  logic [NUM_CONTEXTS-1:0] out_irq_out;
  logic                    out_bad_access;

  logic [PRIO_W-1:0]       prio_m [NUM_SOURCES];
  logic [PRIO_W-1:0]       thr_m [NUM_CONTEXTS];
  logic [NUM_SOURCES-1:0]  en_m [NUM_CONTEXTS];
  logic [NUM_SOURCES-1:0]  pend_m;
  logic [NUM_SOURCES-1:0]  flight_m;

  plic_result_t expected_results[$];
  int unsigned  fails = 0;
  int unsigned  mismatches = 0;
  int unsigned  sink_wait = 0;
  int unsigned  stall_cycles = 0;
  bit           burst_mode = 1'b0;

  platform_interrupt_controller u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_addr       (in_addr),
    .in_wdata      (in_wdata),
    .in_irq_lines  (in_irq_lines),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_rdata     (out_rdata),
    .out_irq_out   (out_irq_out),
    .out_bad_access(out_bad_access)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [ADDR_W-1:0] prio_addr(int unsigned s);
    return ADDR_W'(4 * s);
  endfunction

  function automatic logic [ADDR_W-1:0] en_addr(int unsigned c);
    return EN_BASE + EN_STRIDE * ADDR_W'(c);
  endfunction

  function automatic logic [ADDR_W-1:0] thr_addr(int unsigned c);
    return CTX_BASE + CTX_STRIDE * ADDR_W'(c) + ADDR_W'(CTX_REG_THRESHOLD);
  endfunction

  function automatic logic [ADDR_W-1:0] claim_addr(int unsigned c);
    return CTX_BASE + CTX_STRIDE * ADDR_W'(c) + ADDR_W'(CTX_REG_CLAIM);
  endfunction

  function automatic logic [PRIO_W-1:0] clamp_level(logic [DATA_W-1:0] v);
    return (v > PRIO_MAX) ? PRIO_W'(PRIO_MAX) : v[PRIO_W-1:0];
  endfunction

  function automatic logic [SRC_W-1:0] top_source(int unsigned c);
    logic [SRC_W-1:0]  id;
    logic [PRIO_W-1:0] lvl;
    id  = '0;
    lvl = '0;
    for (int s = 1; s < NUM_SOURCES; s++) begin
      if (en_m[c][s] && pend_m[s] && prio_m[s] > thr_m[c] && prio_m[s] > lvl) begin
        id  = SRC_W'(s);
        lvl = prio_m[s];
      end
    end
    return id;
  endfunction

  task automatic predict_beat(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              input logic [NUM_SOURCES-1:0] lines);
    plic_result_t     r;
    logic [31:0]      a;
    int unsigned      idx;
    int unsigned      cx;
    int unsigned      off;
    int unsigned      reg_off;
    logic [SRC_W-1:0] won;
    bit               wr;
    r  = '0;
    a  = 32'(addr);
    wr = (cmd == CMD_WRITE);
    if (cmd == CMD_SAMPLE) begin
      pend_m |= lines & ~flight_m & ~src_vec_t'(1);
    end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      if (a[1:0] != 2'b00) begin
        r.bad = 1'b1;
      end else if (a < PEND_BASE) begin
        idx = a >> 2;
        if (idx >= NUM_SOURCES) begin
          r.bad = 1'b1;
        end else if (wr) begin
          if (idx != 0) prio_m[idx] = clamp_level(wdata);
        end else begin
          r.rdata = DATA_W'(prio_m[idx]);
        end
      end else if (a < EN_BASE) begin
        idx = (a - PEND_BASE) >> 2;
        if (idx >= EN_WORDS) begin
          r.bad = 1'b1;
        end else if (!wr) begin
          r.rdata = pend_m;
        end
      end else if (a < CTX_BASE) begin
        off = a - EN_BASE;
        cx  = off / EN_STRIDE;
        idx = (off % EN_STRIDE) >> 2;
        if (cx >= NUM_CONTEXTS || idx >= EN_WORDS) begin
          r.bad = 1'b1;
        end else if (wr) begin
          en_m[cx] = wdata & ~src_vec_t'(1);
        end else begin
          r.rdata = en_m[cx];
        end
      end else begin
        off     = a - CTX_BASE;
        cx      = off / CTX_STRIDE;
        reg_off = off % CTX_STRIDE;
        if (cx >= NUM_CONTEXTS || reg_off > CTX_REG_CLAIM) begin
          r.bad = 1'b1;
        end else if (reg_off == CTX_REG_THRESHOLD) begin
          if (wr) thr_m[cx] = clamp_level(wdata);
          else r.rdata = DATA_W'(thr_m[cx]);
        end else if (wr) begin
          if (wdata != 0 && wdata < NUM_SOURCES && en_m[cx][wdata[SRC_W-1:0]]) begin
            flight_m[wdata[SRC_W-1:0]] = 1'b0;
          end
        end else begin
          won = top_source(cx);
          if (won != 0) begin
            pend_m[won]   = 1'b0;
            flight_m[won] = 1'b1;
          end
          r.rdata = DATA_W'(won);
        end
      end
    end
    for (int c = 0; c < NUM_CONTEXTS; c++) begin
      r.irq[c] = (top_source(c) != 0);
    end
    expected_results.push_back(r);
  endtask

  task automatic send_beat(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
                           input logic [DATA_W-1:0] wdata,
                           input logic [NUM_SOURCES-1:0] lines);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_addr      <= addr;
    in_wdata     <= wdata;
    in_irq_lines <= lines;
    do @(posedge clk); while (!in_ready);
    predict_beat(cmd, addr, wdata, lines);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  always @(posedge clk) begin
    plic_result_t want;
    if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        fails++;
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected beat: rdata=%h irq=%b bad=%b",
                   out_rdata, out_irq_out, out_bad_access);
        end
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_rdata !== want.rdata || out_irq_out !== want.irq ||
            out_bad_access !== want.bad) begin
          fails++;
          if (mismatches < MAX_REPORTS) begin
            $display("mismatch at %0t: rdata exp %h got %h, irq exp %b got %b, bad exp %b got %b",
                     $realtime, want.rdata, out_rdata, want.irq, out_irq_out,
                     want.bad, out_bad_access);
          end
          mismatches++;
        end
      end
      sink_wait = burst_mode ? 0 : $urandom_range(0, 6);
      out_ready <= (sink_wait == 0);
    end else if (!out_ready) begin
      if (sink_wait > 0) sink_wait--;
      out_ready <= (sink_wait == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic test_reset_values();
    send_beat(CMD_READ, claim_addr(0), '0, '0);
    send_beat(CMD_READ, en_addr(0), '0, '0);
  endtask

  task automatic test_register_map();
    send_beat(CMD_WRITE, prio_addr(0), '1, '0);
    send_beat(CMD_WRITE, prio_addr(NUM_SOURCES - 1), '1, '0);
    send_beat(CMD_WRITE, PEND_BASE, '1, '0);
    send_beat(CMD_WRITE, en_addr(0), '1, '0);
    send_beat(CMD_WRITE, thr_addr(1), '1, '0);
    send_beat(CMD_READ, thr_addr(1), '0, '0);
    send_beat(CMD_WRITE, thr_addr(1), '0, '0);
    send_beat(CMD_READ, '1, '0, '0);
    send_beat(CMD_WRITE, prio_addr(NUM_SOURCES), '1, '0);
    send_beat(CMD_READ, PEND_BASE + ADDR_W'(4), '0, '0);
    send_beat(CMD_WRITE, en_addr(NUM_CONTEXTS), '1, '0);
    send_beat(CMD_READ, en_addr(0) + ADDR_W'(4), '0, '0);
    send_beat(CMD_READ, claim_addr(NUM_CONTEXTS), '0, '0);
    send_beat(CMD_WRITE, claim_addr(0) + ADDR_W'(4), '1, '0);
    send_beat(CMD_NOP, '1, '1, '1);
  endtask

  task automatic test_claim_complete();
    send_beat(CMD_WRITE, prio_addr(5), 32'd3, '0);
    send_beat(CMD_WRITE, prio_addr(9), 32'd3, '0);
    send_beat(CMD_WRITE, en_addr(1), 32'h0000_0200, '0);
    send_beat(CMD_SAMPLE, '0, '0, '1);
    send_beat(CMD_READ, claim_addr(0), '0, '0);
    send_beat(CMD_READ, claim_addr(0), '0, '0);
    send_beat(CMD_READ, claim_addr(1), '0, '0);
    send_beat(CMD_READ, claim_addr(0), '0, '0);
    send_beat(CMD_WRITE, claim_addr(1), 32'd5, '0);
    send_beat(CMD_WRITE, claim_addr(0), 32'd0, '0);
    send_beat(CMD_WRITE, claim_addr(0), '1, '0);
    send_beat(CMD_WRITE, claim_addr(0), 32'(NUM_SOURCES - 1), '0);
    send_beat(CMD_READ, claim_addr(0), '0, '0);
    send_beat(CMD_SAMPLE, '0, '0, '1);
    send_beat(CMD_READ, claim_addr(0), '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [1:0]             cmd;
    logic [ADDR_W-1:0]      addr;
    logic [DATA_W-1:0]      wdata;
    logic [NUM_SOURCES-1:0] lines;
    int unsigned            pick;
    int unsigned            c;
    int unsigned            s;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      burst_mode = (n % 300) >= 240;
      if (n == 600) drain_results();
      pick  = $urandom_range(0, 99);
      c     = $urandom_range(0, NUM_CONTEXTS - 1);
      cmd   = CMD_READ;
      addr  = ADDR_W'($urandom());
      wdata = $urandom();
      lines = $urandom();
      if (pick < 35) begin
        cmd = CMD_SAMPLE;
        if ($urandom_range(0, 1) == 1) lines = $urandom() & $urandom();
      end else if (pick < 60) begin
        addr = claim_addr(c);
      end else if (pick < 75) begin
        cmd  = CMD_WRITE;
        addr = claim_addr(c);
        if (flight_m != 0 && $urandom_range(0, 4) != 0) begin
          do s = $urandom_range(1, NUM_SOURCES - 1); while (!flight_m[s]);
          wdata = DATA_W'(s);
        end else if ($urandom_range(0, 1) == 1) begin
          wdata = DATA_W'($urandom_range(0, NUM_SOURCES + 8));
        end
      end else if (pick < 88) begin
        cmd = CMD_WRITE;
        case ($urandom_range(0, 2))
          0: begin
            addr = prio_addr($urandom_range(0, NUM_SOURCES - 1));
            if ($urandom_range(0, 4) != 0) wdata = DATA_W'($urandom_range(0, PRIO_MAX));
          end
          1: addr = en_addr(c);
          default: begin
            addr = thr_addr(c);
            if ($urandom_range(0, 4) != 0) wdata = DATA_W'($urandom_range(0, 3));
          end
        endcase
      end else if (pick < 94) begin
        case ($urandom_range(0, 3))
          0: addr = prio_addr($urandom_range(0, NUM_SOURCES - 1));
          1: addr = PEND_BASE;
          2: addr = en_addr(c);
          default: addr = thr_addr(c);
        endcase
      end else begin
        cmd = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 2))
            0: addr = PEND_BASE + ADDR_W'($urandom_range(0, 255));
            1: addr = EN_BASE + ADDR_W'($urandom_range(0, 511));
            default: addr = CTX_BASE + ADDR_W'($urandom_range(0, 'h3fff));
          endcase
        end
      end
      send_beat(cmd, addr, wdata, lines);
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    for (int s = 0; s < NUM_SOURCES; s++) prio_m[s] = '0;
    for (int c = 0; c < NUM_CONTEXTS; c++) begin
      thr_m[c] = '0;
      en_m[c]  = '0;
    end
    pend_m   = '0;
    flight_m = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_register_map();
    test_claim_complete();
    test_random_traffic();
    drain_results();
    repeat (10) @(posedge clk);
    fails += expected_results.size();
    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
